[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wsad assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wsad assertion failed");

`endif

[rtl/wsad_pkg.sv]
// ----------------------------------------------------------------------------
// wsad_pkg
// Types and constants of the wheel slip / ABS detector.
// ----------------------------------------------------------------------------
package wsad_pkg;

	localparam int NUM_WHEELS  = 4;
	localparam int WHEEL_IDX_W = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
	// counter runs over the issue steps plus the pipe drain
	localparam int CNT_W       = $clog2(NUM_WHEELS + 2);

	localparam int SPEED_W  = 13;
	localparam int BRAKE_W  = 10;
	localparam int OMEGA_W  = 18;
	localparam int RADIUS_W = 16;
	localparam int TIME_W   = 32;
	localparam int HOLD_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// |omega| * r fits 33 bits; times 9 fits 37 bits
	localparam int PROD_W = OMEGA_W + RADIUS_W - 1;
	localparam int X9_W   = PROD_W + 4;
	localparam int Q_W    = X9_W - 18;
	// quotient by 10 taken for values below 10 * 2^13 only
	localparam int QL_W   = 17;
	localparam int RECIP_W = 20;
	localparam int RPROD_W = 36;
	localparam int RECIP_SH = 23;

	localparam logic [Q_W-1:0]     SAT_LIMIT = Q_W'(10 * (1 << SPEED_W));
	// ceil(2^23 / 10), exact for dividends below 2^22
	localparam logic [RECIP_W-1:0] RECIP_10  = RECIP_W'(838861);

	localparam logic [CNT_W-1:0] CNT_ISSUE_END = CNT_W'(NUM_WHEELS);
	localparam logic [CNT_W-1:0] CNT_LAST      = CNT_W'(NUM_WHEELS + 1);

	localparam logic [SPEED_W-1:0] MIN_SPEED_RST    = SPEED_W'(160);
	localparam logic [BRAKE_W-1:0] MIN_BRAKE_RST    = BRAKE_W'(100);
	localparam logic [SPEED_W-1:0] TRIGGER_SLIP_RST = SPEED_W'(80);
	localparam logic [HOLD_W-1:0]  HOLD_TIME_RST    = HOLD_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_SPEED    = 2'd0,
		CFG_MIN_BRAKE    = 2'd1,
		CFG_TRIGGER_SLIP = 2'd2,
		CFG_HOLD_TIME    = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                   capture;
		logic                   issue;
		logic [WHEEL_IDX_W-1:0] issue_idx;
		logic                   commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_blocked;
	} dp_status_t;

endpackage

[rtl/wsad_ctrl.sv]
// ----------------------------------------------------------------------------
// wsad_ctrl
// Sequencer: captures a word, steps the wheels through the datapath,
// waits for the pipe to drain and commits the result.
// ----------------------------------------------------------------------------
module wsad_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  wsad_pkg::dp_status_t   status,
	output wsad_pkg::ctrl_cmd_t    cmd
);

	wsad_pkg::state_t               state_q, state_nxt;
	logic [wsad_pkg::CNT_W-1:0]     cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsad_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == wsad_pkg::ST_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			wsad_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = wsad_pkg::ST_RUN;
			end
			wsad_pkg::ST_RUN: begin
				if (cnt_q == wsad_pkg::CNT_LAST) state_nxt = wsad_pkg::ST_FINISH;
			end
			wsad_pkg::ST_FINISH: begin
				if (!status.out_blocked) state_nxt = wsad_pkg::ST_IDLE;
			end
			default: state_nxt = wsad_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.capture   = 1'b0;
		cmd.issue     = 1'b0;
		cmd.issue_idx = cnt_q[wsad_pkg::WHEEL_IDX_W-1:0];
		cmd.commit    = 1'b0;
		unique case (state_q)
			wsad_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			wsad_pkg::ST_RUN: begin
				cmd.issue = (cnt_q < wsad_pkg::CNT_ISSUE_END);
			end
			wsad_pkg::ST_FINISH: begin
				cmd.commit = !status.out_blocked;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[rtl/wsad_datapath.sv]
// ----------------------------------------------------------------------------
// wsad_datapath
// Input and config registers, ground speed pipe (two multipliers),
// running slip maximum, trigger tracking and output register.
// ----------------------------------------------------------------------------
module wsad_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wsad_pkg::ctrl_cmd_t                   cmd,
	output wsad_pkg::dp_status_t                  status,
	// config
	input  logic                                  cfg_we,
	input  logic [wsad_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wsad_pkg::CFG_DATA_W-1:0]       cfg_data,
	// sample
	input  logic [wsad_pkg::SPEED_W-1:0]          vehicle_speed,
	input  logic [wsad_pkg::BRAKE_W-1:0]          brake_level,
	input  logic signed [wsad_pkg::OMEGA_W-1:0]   wheel_speed  [wsad_pkg::NUM_WHEELS],
	input  logic [wsad_pkg::RADIUS_W-1:0]         tyre_radius  [wsad_pkg::NUM_WHEELS],
	input  logic [wsad_pkg::TIME_W-1:0]           time_ms,
	// result
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  abs_active,
	output logic [wsad_pkg::SPEED_W-1:0]          max_slip
);

	// config registers
	logic [wsad_pkg::SPEED_W-1:0] min_speed_q;
	logic [wsad_pkg::BRAKE_W-1:0] min_brake_q;
	logic [wsad_pkg::SPEED_W-1:0] trigger_slip_q;
	logic [wsad_pkg::HOLD_W-1:0]  hold_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q    <= wsad_pkg::MIN_SPEED_RST;
			min_brake_q    <= wsad_pkg::MIN_BRAKE_RST;
			trigger_slip_q <= wsad_pkg::TRIGGER_SLIP_RST;
			hold_time_q    <= wsad_pkg::HOLD_TIME_RST;
		end else if (cfg_we) begin
			unique case (wsad_pkg::cfg_idx_t'(cfg_index))
				wsad_pkg::CFG_MIN_SPEED:    min_speed_q    <= cfg_data[wsad_pkg::SPEED_W-1:0];
				wsad_pkg::CFG_MIN_BRAKE:    min_brake_q    <= cfg_data[wsad_pkg::BRAKE_W-1:0];
				wsad_pkg::CFG_TRIGGER_SLIP: trigger_slip_q <= cfg_data[wsad_pkg::SPEED_W-1:0];
				wsad_pkg::CFG_HOLD_TIME:    hold_time_q    <= cfg_data[wsad_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// captured sample
	logic [wsad_pkg::SPEED_W-1:0]        speed_q;
	logic [wsad_pkg::BRAKE_W-1:0]        brake_q;
	logic [wsad_pkg::TIME_W-1:0]         time_q;
	logic signed [wsad_pkg::OMEGA_W-1:0] omega_q  [wsad_pkg::NUM_WHEELS];
	logic [wsad_pkg::RADIUS_W-1:0]       radius_q [wsad_pkg::NUM_WHEELS];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			speed_q  <= vehicle_speed;
			brake_q  <= brake_level;
			time_q   <= time_ms;
			omega_q  <= wheel_speed;
			radius_q <= tyre_radius;
		end
	end

	// stage 1: |omega| * r
	logic signed [wsad_pkg::OMEGA_W-1:0]    omega_sel;
	logic [wsad_pkg::RADIUS_W-1:0]          radius_sel;
	logic [wsad_pkg::OMEGA_W-1:0]           omega_mag;
	logic [wsad_pkg::PROD_W:0]              mul1;
	logic [wsad_pkg::PROD_W-1:0]            prod_s1;
	logic                                   v_s1;

	assign omega_sel  = omega_q[cmd.issue_idx];
	assign radius_sel = radius_q[cmd.issue_idx];
	// two's complement magnitude; the most negative code maps to 2^17
	assign omega_mag  = omega_sel[wsad_pkg::OMEGA_W-1] ? (~omega_sel + 1'b1) : omega_sel;
	assign mul1 = {{wsad_pkg::RADIUS_W{1'b0}}, omega_mag} *
	              {{wsad_pkg::OMEGA_W{1'b0}}, radius_sel};

	// stage 2: q = floor(9p / 2^18), then q / 10 by reciprocal
	logic [wsad_pkg::X9_W-1:0]      x9;
	logic [wsad_pkg::Q_W-1:0]       q;
	logic                           sat;
	logic [wsad_pkg::QL_W-1:0]      q_lo;
	logic [wsad_pkg::QL_W+wsad_pkg::RECIP_W-1:0] mul2;
	logic [wsad_pkg::RPROD_W-1:0]   prod_s2;
	logic                           sat_s2;
	logic                           v_s2;

	assign x9   = {1'b0, prod_s1, 3'b000} + {4'b0000, prod_s1};
	assign q    = x9[wsad_pkg::X9_W-1:18];
	assign sat  = (q >= wsad_pkg::SAT_LIMIT);   // ground >= 8192, above any speed
	assign q_lo = q[wsad_pkg::QL_W-1:0];
	assign mul2 = {{wsad_pkg::RECIP_W{1'b0}}, q_lo} *
	              {{wsad_pkg::QL_W{1'b0}}, wsad_pkg::RECIP_10};

	// stage 3: slip and running max
	logic [wsad_pkg::SPEED_W-1:0] ground;
	logic [wsad_pkg::SPEED_W-1:0] slip;
	logic [wsad_pkg::SPEED_W-1:0] max_q;

	assign ground = prod_s2[wsad_pkg::RECIP_SH+wsad_pkg::SPEED_W-1:wsad_pkg::RECIP_SH];
	assign slip   = speed_q - ground;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul1[wsad_pkg::PROD_W-1:0];
		prod_s2 <= mul2[wsad_pkg::RPROD_W-1:0];
		sat_s2  <= sat;
		if (cmd.capture) begin
			max_q <= '0;
		end else if (v_s2 && !sat_s2 && (ground < speed_q) && (slip > max_q)) begin
			max_q <= slip;
		end
	end

	// finish: gate, trigger, hold window
	logic                         gated;
	logic [wsad_pkg::SPEED_W-1:0] slip_fin;
	logic                         triggered;
	logic [wsad_pkg::TIME_W-1:0]  last_trigger_q;
	logic [wsad_pkg::TIME_W-1:0]  elapsed;
	logic                         window_open;

	assign gated       = (speed_q < min_speed_q) || (brake_q < min_brake_q);
	assign slip_fin    = gated ? '0 : max_q;
	assign triggered   = !gated && (slip_fin > trigger_slip_q);
	assign elapsed     = time_q - last_trigger_q;
	assign window_open = elapsed < {{(wsad_pkg::TIME_W-wsad_pkg::HOLD_W){1'b0}}, hold_time_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_trigger_q <= '0;
			out_valid      <= 1'b0;
		end else begin
			if (cmd.commit && triggered) last_trigger_q <= time_q;
			if (cmd.commit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			abs_active <= triggered || window_open;
			max_slip   <= slip_fin;
		end
	end

	assign status.out_blocked = out_valid && !out_ready;

endmodule

[rtl/wheel_slip_abs_detector.sv]
// ----------------------------------------------------------------------------
// wheel_slip_abs_detector
// Wheel slip detection with an ABS hold window, one result per sample.
// ----------------------------------------------------------------------------
// From acceptance to the next in_ready a sample passes an accept step,
// one issue per wheel into the shared two-multiplier ground speed pipe,
// a drain of that pipe, and a commit into the output register. Samples
// are worked one at a time; the next sample is taken while the previous
// result still waits in the output register, and the commit waits only
// when that register is still full. Ground speed is
// floor(|omega| * r * 9 / (10 * 2^18)) in 1/16 km/h, with the divide by 10
// done as a multiply by a reciprocal. Samples below either gate report 0
// slip and only the state of the hold window. Config writes are always
// accepted and should be made only while the block is idle.
// ----------------------------------------------------------------------------
module wheel_slip_abs_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wsad_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wsad_pkg::CFG_DATA_W-1:0]     cfg_data,
	// sample channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [wsad_pkg::SPEED_W-1:0]        vehicle_speed,
	input  logic [wsad_pkg::BRAKE_W-1:0]        brake_level,
	input  logic signed [wsad_pkg::OMEGA_W-1:0] wheel_speed_0,
	input  logic signed [wsad_pkg::OMEGA_W-1:0] wheel_speed_1,
	input  logic signed [wsad_pkg::OMEGA_W-1:0] wheel_speed_2,
	input  logic signed [wsad_pkg::OMEGA_W-1:0] wheel_speed_3,
	input  logic [wsad_pkg::RADIUS_W-1:0]       tyre_radius_0,
	input  logic [wsad_pkg::RADIUS_W-1:0]       tyre_radius_1,
	input  logic [wsad_pkg::RADIUS_W-1:0]       tyre_radius_2,
	input  logic [wsad_pkg::RADIUS_W-1:0]       tyre_radius_3,
	input  logic [wsad_pkg::TIME_W-1:0]         time_ms,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                abs_active,
	output logic [wsad_pkg::SPEED_W-1:0]        max_slip
);

	wsad_pkg::ctrl_cmd_t  cmd;
	wsad_pkg::dp_status_t status;

	logic signed [wsad_pkg::OMEGA_W-1:0] omega_arr  [wsad_pkg::NUM_WHEELS];
	logic [wsad_pkg::RADIUS_W-1:0]       radius_arr [wsad_pkg::NUM_WHEELS];

	// wheel order: front left, front right, rear left, rear right
	assign omega_arr[0]  = wheel_speed_0;
	assign omega_arr[1]  = wheel_speed_1;
	assign omega_arr[2]  = wheel_speed_2;
	assign omega_arr[3]  = wheel_speed_3;
	assign radius_arr[0] = tyre_radius_0;
	assign radius_arr[1] = tyre_radius_1;
	assign radius_arr[2] = tyre_radius_2;
	assign radius_arr[3] = tyre_radius_3;

	// register file never stalls a write
	assign cfg_ready = 1'b1;

	wsad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	wsad_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.vehicle_speed (vehicle_speed),
		.brake_level   (brake_level),
		.wheel_speed   (omega_arr),
		.tyre_radius   (radius_arr),
		.time_ms       (time_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.abs_active    (abs_active),
		.max_slip      (max_slip)
	);

endmodule

[rtl/wsad_checker.sv]
// ----------------------------------------------------------------------------
// wsad_checker
// Port-level checks on the detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsad_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           abs_active,
	input logic [wsad_pkg::SPEED_W-1:0]   max_slip
);

	// a stalled result word stays up and unchanged
	`WSAD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`WSAD_ASSERT_NXT(a_out_stable_slip, clk, arst_n, out_valid && !out_ready, $stable(max_slip))
	`WSAD_ASSERT_NXT(a_out_stable_abs, clk, arst_n, out_valid && !out_ready, $stable(abs_active))

	// one sample in flight: no new word taken right after one is accepted
	`WSAD_ASSERT_NXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)

	// a result never appears the cycle after acceptance
	`WSAD_ASSERT_NXT(a_no_early_result, clk, arst_n, in_valid && in_ready, !$rose(out_valid))

endmodule

bind wheel_slip_abs_detector wsad_checker u_wsad_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.abs_active (abs_active),
	.max_slip   (max_slip)
);

[bench/tb_wheel_slip_abs_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wheel_slip_abs_detector
// Self-checking bench for the wheel slip / ABS hold window detector.
// ----------------------------------------------------------------------------
// Samples go in through the valid/ready sample channel. Each accepted word
// is run through a local slip predictor, which keeps its own copy of the
// gate registers and of the last trigger time. The expected result is
// queued. A monitor pops the queue on every result word and compares it
// field by field. Directed tests cover reset state, the gates, field
// extremes, time wrap and register masking. A long random run then drives
// plausible braking sequences with some noise under several gate settings.
// Both channels stall at random, with stretches of no stalling.
// ----------------------------------------------------------------------------
module tb_wheel_slip_abs_detector;
	import wsad_pkg::*;

	// every sample yields a result, so an empty queue means the block is idle;
	// the extra settle wait covers the pipe anyway
	localparam int SETTLE_CYCLES = NUM_WHEELS + 8;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_WORDS   = 275;
	// ground speed = |omega| * r * 576 / (10 * 2^24)
	localparam longint unsigned KMH16_MUL = 576;
	localparam longint unsigned KMH16_DIV = 167772160;

	typedef struct packed {
		logic [SPEED_W-1:0]                   speed;
		logic [BRAKE_W-1:0]                   brake;
		logic [NUM_WHEELS-1:0][OMEGA_W-1:0]   omega;
		logic [NUM_WHEELS-1:0][RADIUS_W-1:0]  radius;
		logic [TIME_W-1:0]                    stamp;
	} wheel_sample_t;

	typedef struct packed {
		logic               abs_active;
		logic [SPEED_W-1:0] max_slip;
	} slip_result_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic                       in_valid;
	logic                       in_ready;
	logic [SPEED_W-1:0]         vehicle_speed;
	logic [BRAKE_W-1:0]         brake_level;
	logic signed [OMEGA_W-1:0]  wheel_speed_0;
	logic signed [OMEGA_W-1:0]  wheel_speed_1;
	logic signed [OMEGA_W-1:0]  wheel_speed_2;
	logic signed [OMEGA_W-1:0]  wheel_speed_3;
	logic [RADIUS_W-1:0]        tyre_radius_0;
	logic [RADIUS_W-1:0]        tyre_radius_1;
	logic [RADIUS_W-1:0]        tyre_radius_2;
	logic [RADIUS_W-1:0]        tyre_radius_3;
	logic [TIME_W-1:0]          time_ms;

	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               abs_active;
	logic [SPEED_W-1:0] max_slip;

	// predictor's copy of the gate registers and the trigger state
	logic [SPEED_W-1:0] gate_speed;
	logic [BRAKE_W-1:0] gate_brake;
	logic [SPEED_W-1:0] slip_limit;
	logic [HOLD_W-1:0]  hold_ms;
	logic [TIME_W-1:0]  trig_time;

	slip_result_t expected_slips[$];
	int           errors = 0;
	bit           idle_on = 1'b1;
	int           ready_hold = 0;
	// running clock of the simulated drive
	logic [TIME_W-1:0] road_clock = '0;

	wheel_slip_abs_detector dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.vehicle_speed (vehicle_speed),
		.brake_level   (brake_level),
		.wheel_speed_0 (wheel_speed_0),
		.wheel_speed_1 (wheel_speed_1),
		.wheel_speed_2 (wheel_speed_2),
		.wheel_speed_3 (wheel_speed_3),
		.tyre_radius_0 (tyre_radius_0),
		.tyre_radius_1 (tyre_radius_1),
		.tyre_radius_2 (tyre_radius_2),
		.tyre_radius_3 (tyre_radius_3),
		.time_ms       (time_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.abs_active    (abs_active),
		.max_slip      (max_slip)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Slip predictor
	// ------------------------------------------------------------------

	// hold window measured modulo 2^32, so it survives the time wrap
	function automatic logic hold_open(input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] elapsed;
		elapsed = now - trig_time;
		return elapsed < TIME_W'(hold_ms);
	endfunction

	// works out the result of one sample and advances the trigger state
	function automatic slip_result_t predict_slip(input wheel_sample_t s);
		slip_result_t      r;
		longint unsigned   mag;
		longint unsigned   ground;
		longint unsigned   worst;
		logic              fired;
		worst = 0;
		r.abs_active = 1'b0;
		r.max_slip   = '0;
		// gated: no detection, only the state of the window
		if (s.speed < gate_speed || s.brake < gate_brake) begin
			r.abs_active = hold_open(s.stamp);
			return r;
		end
		for (int i = 0; i < NUM_WHEELS; i++) begin
			mag = longint'(s.omega[i]);
			// two's complement magnitude; -2^17 gives 2^17
			if (s.omega[i][OMEGA_W-1])
				mag = (longint'(1) << OMEGA_W) - mag;
			ground = (mag * longint'(s.radius[i]) * KMH16_MUL) / KMH16_DIV;
			// a wheel faster than the car counts as no slip
			if (ground < longint'(s.speed) && longint'(s.speed) - ground > worst)
				worst = longint'(s.speed) - ground;
		end
		fired = worst > longint'(slip_limit);
		if (fired)
			trig_time = s.stamp;
		r.abs_active = fired || hold_open(s.stamp);
		r.max_slip   = SPEED_W'(worst);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result monitor: one stall draw per result word
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		slip_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_hold = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_slips.size() == 0) begin
					$error("result word with nothing expected: abs_active %0d max_slip %0d",
						abs_active, max_slip);
					errors++;
				end else begin
					want = expected_slips.pop_front();
					if (abs_active !== want.abs_active) begin
						$error("abs_active: expected %0d, got %0d", want.abs_active, abs_active);
						errors++;
					end
					if (max_slip !== want.max_slip) begin
						$error("max_slip: expected %0d, got %0d", want.max_slip, max_slip);
						errors++;
					end
				end
				ready_hold = idle_on ? $urandom_range(0, 9) : 0;
			end else if (ready_hold != 0) begin
				ready_hold--;
			end
			out_ready <= (ready_hold == 0);
		end
	end

	// ------------------------------------------------------------------
	// Shared drivers
	// ------------------------------------------------------------------

	// Sends one sample word. Valid is left high after acceptance: the next
	// call either keeps it up (no gap) or drops it first, so each signal
	// gets a single assignment per edge.
	task automatic send_sample(input wheel_sample_t s);
		int gap;
		gap = idle_on ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		vehicle_speed <= s.speed;
		brake_level   <= s.brake;
		wheel_speed_0 <= s.omega[0];
		wheel_speed_1 <= s.omega[1];
		wheel_speed_2 <= s.omega[2];
		wheel_speed_3 <= s.omega[3];
		tyre_radius_0 <= s.radius[0];
		tyre_radius_1 <= s.radius[1];
		tyre_radius_2 <= s.radius[2];
		tyre_radius_3 <= s.radius[3];
		time_ms       <= s.stamp;
		do @(posedge clk); while (!in_ready);
		expected_slips.push_back(predict_slip(s));
	endtask

	// stop sending and wait until every expected word is back
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (expected_slips.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		// registers keep only their own width
		case (idx)
			CFG_MIN_SPEED:    gate_speed = data[SPEED_W-1:0];
			CFG_MIN_BRAKE:    gate_brake = data[BRAKE_W-1:0];
			CFG_TRIGGER_SLIP: slip_limit = data[SPEED_W-1:0];
			CFG_HOLD_TIME:    hold_ms    = data[HOLD_W-1:0];
			default: ;
		endcase
	endtask

	// only ever called with the block idle
	task automatic program_gates(input logic [CFG_DATA_W-1:0] spd, input logic [CFG_DATA_W-1:0] brk,
		input logic [CFG_DATA_W-1:0] trg, input logic [CFG_DATA_W-1:0] hld);
		wait_results_drained();
		write_reg(CFG_MIN_SPEED, spd);
		write_reg(CFG_MIN_BRAKE, brk);
		write_reg(CFG_TRIGGER_SLIP, trg);
		write_reg(CFG_HOLD_TIME, hld);
		cfg_valid <= 1'b0;
	endtask

	// car at standstill wheels: omega 0 on typical tyres
	function automatic wheel_sample_t still_sample(input int spd, input int brk,
		input logic [TIME_W-1:0] stamp);
		wheel_sample_t s;
		s.speed = SPEED_W'(spd);
		s.brake = BRAKE_W'(brk);
		s.stamp = stamp;
		for (int i = 0; i < NUM_WHEELS; i++) begin
			s.omega[i]  = '0;
			s.radius[i] = RADIUS_W'(20000);
		end
		return s;
	endfunction

	// plausible braking sample: wheels a bit slower or faster than the car
	function automatic wheel_sample_t road_sample();
		wheel_sample_t   s;
		int              slip;
		longint          ground;
		longint unsigned w;
		road_clock = road_clock + ($urandom_range(0, 1) ? $urandom_range(0, 60)
			: $urandom_range(0, 400));
		s.stamp = road_clock;
		s.speed = SPEED_W'($urandom_range(gate_speed, (1 << SPEED_W) - 1));
		s.brake = (gate_brake <= 1000) ? BRAKE_W'($urandom_range(gate_brake, 1000))
			: BRAKE_W'($urandom_range(0, 1000));
		for (int i = 0; i < NUM_WHEELS; i++) begin
			s.radius[i] = RADIUS_W'($urandom_range(16000, 26000));
			slip = int'($urandom_range(0, 2 * slip_limit + 64)) - 24;
			ground = longint'(s.speed) - slip;
			if (ground < 0)
				ground = 0;
			w = (longint'(ground) * KMH16_DIV) / (longint'(s.radius[i]) * KMH16_MUL);
			if (w > (1 << (OMEGA_W - 1)) - 1)
				w = (1 << (OMEGA_W - 1)) - 1;
			// reversing wheel now and then
			s.omega[i] = ($urandom_range(0, 7) == 0) ? -OMEGA_W'(w) : OMEGA_W'(w);
		end
		// broken sequence: pedal may drop below the gate mid-stop
		if ($urandom_range(0, 15) == 0)
			s.brake = BRAKE_W'($urandom_range(0, 1000));
		return s;
	endfunction

	// anything the fields allow, with brake kept to 0..1000
	function automatic wheel_sample_t noise_sample();
		wheel_sample_t s;
		s.speed = SPEED_W'($urandom);
		s.brake = BRAKE_W'($urandom_range(0, 1000));
		for (int i = 0; i < NUM_WHEELS; i++) begin
			s.omega[i]  = OMEGA_W'($urandom);
			s.radius[i] = RADIUS_W'($urandom);
		end
		s.stamp = $urandom_range(0, 1) ? TIME_W'($urandom) : road_clock;
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// last trigger is 0 after reset, so early times see the window open
	task automatic test_after_reset();
		send_sample(still_sample(0, 0, 32'd0));
		send_sample(still_sample(0, 0, 32'd99));
		send_sample(still_sample(0, 0, 32'd100));
		send_sample(still_sample(0, 0, 32'hFFFF_FFFF));
	endtask

	// gates are "below": equal to the gate is detected
	task automatic test_gates();
		send_sample(still_sample(160, 100, 32'd1000));
		send_sample(still_sample(159, 1000, 32'd1050));
		send_sample(still_sample(8191, 99, 32'd1090));
		send_sample(still_sample(8191, 1000, 32'd1300));
	endtask

	task automatic test_field_extremes();
		wheel_sample_t s;
		// fastest wheels on biggest tyres: ground far above the car
		s = still_sample(8191, 1000, 32'd5000);
		for (int i = 0; i < NUM_WHEELS; i++) begin
			s.omega[i]  = OMEGA_W'(131071);
			s.radius[i] = 16'hFFFF;
		end
		send_sample(s);
		// most negative omega, mixed with locked and zero radius wheels
		s.omega[0] = OMEGA_W'(-131072);
		s.omega[1] = '0;
		s.radius[2] = '0;
		s.stamp = 32'd5001;
		send_sample(s);
		// wheels close to the car's speed, only wheel 0 slightly slow, no trigger
		s = still_sample(8191, 1000, 32'd5400);
		for (int i = 0; i < NUM_WHEELS; i++) begin
			s.radius[i] = 16'hFFFF;
			s.omega[i]  = OMEGA_W'(36400 + 10 * i);
		end
		send_sample(s);
		s.omega[3] = OMEGA_W'(-36400);
		s.stamp = 32'd5401;
		send_sample(s);
	endtask

	// trigger just before the wrap, then look across it
	task automatic test_time_wrap();
		send_sample(still_sample(4000, 500, 32'hFFFF_FFC0));
		send_sample(still_sample(0, 0, 32'h0000_0010));
		send_sample(still_sample(0, 0, 32'h0000_0030));
	endtask

	// writes wider than the register, then everything at zero
	task automatic test_register_extremes();
		program_gates(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_sample(still_sample(8191, 1000, 32'd7000));
		send_sample(still_sample(8191, 1000, 32'd7001));
		program_gates(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		// zero slip does not exceed a zero trigger, and a zero hold never opens
		send_sample(still_sample(0, 0, 32'd7100));
		send_sample(still_sample(1, 0, 32'd7200));
		send_sample(still_sample(0, 0, 32'd7200));
		program_gates(16'd160, 16'd100, 16'd80, 16'd100);
	endtask

	task automatic test_random_driving();
		logic [CFG_DATA_W-1:0] spd, brk, trg, hld;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin spd = 160;  brk = 100;  trg = 80;   hld = 100;   end
				1: begin spd = 0;    brk = 0;    trg = 0;    hld = 0;     end
				2: begin spd = 4000; brk = 500;  trg = 8191; hld = 65535; end
				3: begin spd = 16;   brk = 0;    trg = 1;    hld = 1;     end
				4: begin
					spd = CFG_DATA_W'($urandom_range(0, 1600));
					brk = CFG_DATA_W'($urandom_range(0, 600));
					trg = CFG_DATA_W'($urandom_range(0, 400));
					hld = CFG_DATA_W'($urandom_range(0, 1000));
				end
				default: begin spd = 8191; brk = 1000; trg = 40; hld = 300; end
			endcase
			// this is also the point where the sender waits for all results
			program_gates(spd, brk, trg, hld);
			if (p == RANDOM_PHASES - 1)
				road_clock = 32'hFFFF_F000;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 50 == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 4) == 0)
					send_sample(noise_sample());
				else
					send_sample(road_sample());
			end
		end
		idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= CFG_MIN_SPEED;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		vehicle_speed <= '0;
		brake_level   <= '0;
		wheel_speed_0 <= '0;
		wheel_speed_1 <= '0;
		wheel_speed_2 <= '0;
		wheel_speed_3 <= '0;
		tyre_radius_0 <= '0;
		tyre_radius_1 <= '0;
		tyre_radius_2 <= '0;
		tyre_radius_3 <= '0;
		time_ms       <= '0;
		gate_speed = MIN_SPEED_RST;
		gate_brake = MIN_BRAKE_RST;
		slip_limit = TRIGGER_SLIP_RST;
		hold_ms    = HOLD_TIME_RST;
		trig_time  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_gates();
		test_field_extremes();
		test_time_wrap();
		test_register_extremes();
		test_random_driving();

		wait_results_drained();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// timeout well beyond the worst case run
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
